>>> src/srpq_pkg.sv
// Shared types and constants for the sorted priority ready queue.
package srpq_pkg;

    localparam int ID_W       = 16;
    localparam int PRIO_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 7;
    localparam int DEPTH_DEF  = 64;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [PRIO_W-1:0] FLAT_PRIORITY = 8'd1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Broadcast control from the queue controller to every cell
    typedef struct packed {
        logic   push;   // accepted push into a non-full queue
        logic   pop;    // accepted pop from a non-empty queue
        entry_t ins;    // entry being inserted
    } cell_cmd_t;

endpackage

>>> src/srpq_cell.sv
// One storage cell of the sorted insertion chain.
module srpq_cell (
    input  logic               aclk,
    input  srpq_pkg::cell_cmd_t cmd,
    input  logic               occupied,   // cell index below the entry count
    input  logic               left_keep,  // left neighbor holds its entry on push
    input  srpq_pkg::entry_t   left_q,
    input  srpq_pkg::entry_t   right_q,
    output logic               keep,
    output srpq_pkg::entry_t   q
);

    srpq_pkg::entry_t entry_reg;
    srpq_pkg::entry_t entry_next;

    // Stored entries form a sorted prefix, so keep is true on a prefix too
    assign keep = occupied && (entry_reg.prio >= cmd.ins.prio);
    assign q    = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        priority if (cmd.push) begin
            if (!keep) begin
                entry_next = left_keep ? cmd.ins : left_q;
            end
        end else if (cmd.pop) begin
            entry_next = right_q;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> src/sorted_priority_ready_queue_unit.sv
// Top level of the sorted priority ready queue: controller, cell chain, result register.
//
//  channel  | direction | ports                                             | meaning
//  ---------+-----------+---------------------------------------------------+-----------------
//  s_       | in        | s_valid s_ready s_mode s_task_id s_task_priority  | push or pop
//  m_       | out       | m_valid m_ready m_status m_out_task_id            | one per request
//           |           | m_out_priority m_occupancy                        |
//  cfg_     | in        | cfg_valid cfg_ready cfg_ignore_priority           | priority mode
//
// For each request, every cell compares its stored priority with the incoming one in
// parallel, then holds, loads the new entry or takes its neighbor's entry.
// The result is valid the cycle after acceptance; one transaction per cycle while m_ready
// is high. The result register is the only stall point: s_ready is high when it is empty
// or being drained in the same cycle. Both ready outputs stay low while aresetn is low.
// Reset (synchronous) empties the queue and clears ignore_priority; cells are not cleared.
module sorted_priority_ready_queue_unit #(
    parameter int QUEUE_DEPTH = srpq_pkg::DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_mode,
    input  logic [srpq_pkg::ID_W-1:0]       s_task_id,
    input  logic [srpq_pkg::PRIO_W-1:0]     s_task_priority,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [srpq_pkg::STATUS_W-1:0]   m_status,
    output logic [srpq_pkg::ID_W-1:0]       m_out_task_id,
    output logic [srpq_pkg::PRIO_W-1:0]     m_out_priority,
    output logic [srpq_pkg::OCC_W-1:0]      m_occupancy,
    // configuration channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_ignore_priority
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // control state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ignore_prio_reg;
    logic              m_valid_reg;

    // result payload
    logic [srpq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [srpq_pkg::ID_W-1:0]     oid_reg, oid_next;
    logic [srpq_pkg::PRIO_W-1:0]   oprio_reg, oprio_next;
    logic [srpq_pkg::OCC_W-1:0]    occ_reg, occ_next;

    logic                s_fire;
    logic                is_full, is_empty;
    srpq_pkg::cell_cmd_t cmd;
    logic [CNT_W+srpq_pkg::OCC_W-1:0] count_wide;

    // chain wiring
    srpq_pkg::entry_t cell_q    [QUEUE_DEPTH];
    logic             cell_keep [QUEUE_DEPTH];

    assign cfg_ready = aresetn;
    assign s_ready   = aresetn && (!m_valid_reg || m_ready);
    assign s_fire    = s_valid && s_ready;

    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    // Flat priority mode stores every entry with the same priority: FIFO order
    always_comb begin
        cmd.push      = s_fire && !s_mode && !is_full;
        cmd.pop       = s_fire && s_mode && !is_empty;
        cmd.ins.id    = s_task_id;
        cmd.ins.prio  = ignore_prio_reg ? srpq_pkg::FLAT_PRIORITY : s_task_priority;
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic             occ_bit;
            logic             lkeep;
            srpq_pkg::entry_t lq;
            srpq_pkg::entry_t rq;

            assign occ_bit = (count_reg > CNT_W'(gi));

            if (gi == 0) begin : g_head
                // head cell: everything to its left "keeps"
                assign lkeep = 1'b1;
                assign lq    = cmd.ins;
            end else begin : g_body
                assign lkeep = cell_keep[gi-1];
                assign lq    = cell_q[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                // tail cell: on pop it becomes unoccupied, data is don't-care
                assign rq = cmd.ins;
            end else begin : g_mid
                assign rq = cell_q[gi+1];
            end

            srpq_cell u_cell (
                .aclk      (aclk),
                .cmd       (cmd),
                .occupied  (occ_bit),
                .left_keep (lkeep),
                .left_q    (lq),
                .right_q   (rq),
                .keep      (cell_keep[gi]),
                .q         (cell_q[gi])
            );
        end
    endgenerate

    // count and result
    always_comb begin
        count_next  = count_reg;
        status_next = srpq_pkg::ST_OK;
        oid_next    = '0;
        oprio_next  = '0;
        if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
            oid_next   = cell_q[0].id;
            oprio_next = cell_q[0].prio;
        end
        if (!s_mode && is_full) begin
            status_next = srpq_pkg::ST_FULL;
        end else if (s_mode && is_empty) begin
            status_next = srpq_pkg::ST_EMPTY;
        end
        count_wide = {{srpq_pkg::OCC_W{1'b0}}, count_next};
        occ_next   = count_wide[srpq_pkg::OCC_W-1:0];  // low bits for deep queues
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            ignore_prio_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                ignore_prio_reg <= cfg_ignore_priority;
            end
            if (s_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg <= status_next;
            oid_reg    <= oid_next;
            oprio_reg  <= oprio_next;
            occ_reg    <= occ_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_out_task_id  = oid_reg;
    assign m_out_priority = oprio_reg;
    assign m_occupancy    = occ_reg;

endmodule

>>> tb/sorted_priority_ready_queue_unit_test.sv
// Self-checking testbench for the sorted priority ready queue unit.
`timescale 1ns / 100ps

module sorted_priority_ready_queue_unit_test;

    localparam int  QDEPTH     = srpq_pkg::DEPTH_DEF;
    localparam int  CYCLE_CAP  = 200_000;  // far above the slowest legal run
    localparam int  SEG_ITEMS  = 78;       // 9 random segments, about 700 items
    localparam int  DRAIN_WAIT = 5;        // result register is one stage deep
    localparam bit  MODE_PUSH  = 1'b0;
    localparam bit  MODE_POP   = 1'b1;

    typedef struct {
        logic [srpq_pkg::STATUS_W-1:0] status;
        logic [srpq_pkg::ID_W-1:0]     id;
        logic [srpq_pkg::PRIO_W-1:0]   prio;
        logic [srpq_pkg::OCC_W-1:0]    occ;
    } queue_result_t;

    // Predictor plus pending-result store. The held list mirrors the cell chain,
    // head at index 0.
    class ready_queue_scoreboard;
        srpq_pkg::entry_t held[$];
        queue_result_t    due[$];
        bit               flat_mode;
        int               errors;
        int               n_push, n_full, n_pop, n_empty, n_cfg;

        function void set_flat(bit value);
            flat_mode = value;
            n_cfg++;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void report(string field, int unsigned exp_v, int unsigned act_v);
            errors++;
            $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
        endfunction

        // Called once per accepted request transaction.
        function void note_request(bit mode, logic [srpq_pkg::ID_W-1:0] id,
                                   logic [srpq_pkg::PRIO_W-1:0] prio);
            queue_result_t    r;
            srpq_pkg::entry_t e;
            int               pos;
            r.status = srpq_pkg::ST_OK;
            r.id     = '0;
            r.prio   = '0;
            if (mode == MODE_PUSH) begin
                n_push++;
                if (held.size() >= QDEPTH) begin
                    r.status = srpq_pkg::ST_FULL;
                    n_full++;
                end else begin
                    e.id   = id;
                    e.prio = flat_mode ? srpq_pkg::FLAT_PRIORITY : prio;
                    // new entry lands behind every entry of higher or equal priority
                    pos = 0;
                    while (pos < held.size() && held[pos].prio >= e.prio)
                        pos++;
                    held.insert(pos, e);
                end
            end else begin
                n_pop++;
                if (held.size() == 0) begin
                    r.status = srpq_pkg::ST_EMPTY;
                    n_empty++;
                end else begin
                    e      = held.pop_front();
                    r.id   = e.id;
                    r.prio = e.prio;
                end
            end
            r.occ = srpq_pkg::OCC_W'(held.size());
            due.push_back(r);
        endfunction

        // Called once per accepted result transaction.
        function void check_result(logic [srpq_pkg::STATUS_W-1:0] status,
                                   logic [srpq_pkg::ID_W-1:0] id,
                                   logic [srpq_pkg::PRIO_W-1:0] prio,
                                   logic [srpq_pkg::OCC_W-1:0] occ);
            queue_result_t r;
            if (due.size() == 0) begin
                errors++;
                $error("result transaction with no request outstanding");
                return;
            end
            r = due.pop_front();
            if (status !== r.status) report("status", r.status, status);
            if (id !== r.id)         report("out_task_id", r.id, id);
            if (prio !== r.prio)     report("out_priority", r.prio, prio);
            if (occ !== r.occ)       report("occupancy", r.occ, occ);
        endfunction
    endclass

    // All block inputs start at known values.
    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_mode = MODE_PUSH;
    logic [srpq_pkg::ID_W-1:0]     s_task_id = '0;
    logic [srpq_pkg::PRIO_W-1:0]   s_task_priority = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [srpq_pkg::STATUS_W-1:0] m_status;
    logic [srpq_pkg::ID_W-1:0]     m_out_task_id;
    logic [srpq_pkg::PRIO_W-1:0]   m_out_priority;
    logic [srpq_pkg::OCC_W-1:0]    m_occupancy;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_ignore_priority = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    ready_queue_scoreboard sb = new();

    sorted_priority_ready_queue_unit #(
        .QUEUE_DEPTH (QDEPTH)
    ) u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_task_id           (s_task_id),
        .s_task_priority     (s_task_priority),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_out_task_id       (m_out_task_id),
        .m_out_priority      (m_out_priority),
        .m_occupancy         (m_occupancy),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_ignore_priority (cfg_ignore_priority)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side: sample at the edge, then pick the next ready value. Values read
    // in the active region at posedge are the pre-edge values, so no race with
    // the block's own registers.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_out_task_id, m_out_priority, m_occupancy);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop if the block hangs.
    initial begin
        repeat (CYCLE_CAP) @(posedge aclk);
        $display("sorted_priority_ready_queue_unit_test NOT OK");
        $finish;
    end

    // One request transaction. Valid is dropped only during random gaps, so a
    // back-to-back item never sees valid lowered and raised in the same step.
    task automatic send_request(bit mode, logic [srpq_pkg::ID_W-1:0] id,
                                logic [srpq_pkg::PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_task_id       <= id;
        s_task_priority <= prio;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(mode, id, prio);
    endtask

    // Priority-mode write, only once every outstanding result is back.
    task automatic write_priority_mode(bit value);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        cfg_valid           <= 1'b1;
        cfg_ignore_priority <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_flat(value);
    endtask

    // Priorities cluster on a few values half the time so ties are common.
    function automatic logic [srpq_pkg::PRIO_W-1:0] pick_priority();
        unique case ($urandom_range(3))
            0:       return srpq_pkg::PRIO_W'($urandom_range(2));
            1:       return srpq_pkg::PRIO_W'(8'hFF - $urandom_range(1));
            default: return srpq_pkg::PRIO_W'($urandom_range(255));
        endcase
    endfunction

    // A segment biased toward pushes fills the queue past full, one biased toward
    // pops drains it past empty.
    task automatic run_segment(int unsigned push_pct);
        for (int i = 0; i < SEG_ITEMS; i++) begin
            if ($urandom_range(99) < push_pct)
                send_request(MODE_PUSH, srpq_pkg::ID_W'($urandom), pick_priority());
            else
                send_request(MODE_POP, srpq_pkg::ID_W'($urandom),
                             srpq_pkg::PRIO_W'($urandom));
        end
    endtask

    initial begin
        int unsigned push_mix [3];
        push_mix = '{95, 50, 10};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct  = 19;
        recv_stall_pct = 54;
        write_priority_mode(1'b0);

        // Directed: empty pop, field extremes, FIFO order among equal priorities.
        send_request(MODE_POP,  16'h0000, 8'h00);
        send_request(MODE_PUSH, 16'h0000, 8'h00);
        send_request(MODE_PUSH, 16'hFFFF, 8'hFF);
        send_request(MODE_PUSH, 16'h1234, 8'h80);
        send_request(MODE_PUSH, 16'h1235, 8'h80);
        send_request(MODE_PUSH, 16'h1236, 8'h80);
        send_request(MODE_PUSH, 16'h00FF, 8'h00);
        repeat (7) send_request(MODE_POP, 16'hFFFF, 8'hFF);

        // Flat mode: arrival order regardless of the requested priority.
        write_priority_mode(1'b1);
        send_request(MODE_PUSH, 16'hA000, 8'd200);
        send_request(MODE_PUSH, 16'hB000, 8'd5);
        send_request(MODE_PUSH, 16'hC000, 8'd255);
        send_request(MODE_POP,  16'h0000, 8'h00);
        // Mode change with entries stored: they keep priority 1, a later
        // priority-2 push overtakes them.
        write_priority_mode(1'b0);
        send_request(MODE_PUSH, 16'hD000, 8'd2);
        repeat (3) send_request(MODE_POP, 16'h0000, 8'h00);

        // Random part: three idle profiles, each with fill, mixed and drain
        // segments, priority mode flipped between segments.
        for (int p = 0; p < 3; p++) begin
            unique case (p)
                0: begin send_idle_pct = 19; recv_stall_pct = 54; end
                1: begin send_idle_pct = 54; recv_stall_pct = 19; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int s = 0; s < 3; s++) begin
                write_priority_mode(bit'((p + s) % 2));
                run_segment(push_mix[s]);
            end
        end

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered %0d pushes (%0d refused on full) and %0d pops (%0d on empty),",
                 sb.n_push, sb.n_full, sb.n_pop, sb.n_empty);
        $display("with %0d priority-mode writes across three handshake idle profiles.",
                 sb.n_cfg);
        if (sb.errors == 0)
            $display("sorted_priority_ready_queue_unit_test OK");
        else
            $display("sorted_priority_ready_queue_unit_test NOT OK");
        $finish;
    end

endmodule
